@@ rtl/core/ftba_pkg.sv @@
// Shared types and constants of the file table block allocator.
package ftba_pkg;

    localparam int CMD_W    = 2;
    localparam int ID_W     = 16;
    localparam int SLOT_W   = 4;
    localparam int BLOCK_W  = 9;
    localparam int WORD_W   = 32;
    localparam int WORD_LOG = 5;

    // Free-map word 0 after reset: blocks 0 and 1 reserved.
    localparam logic [WORD_W-1:0] RESET_WORD0 = 32'h0000_0003;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_CREATE = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_RSVD   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_EXISTS    = 3'd2,
        ST_NO_SLOT   = 3'd3,
        ST_NO_BLOCK  = 3'd4,
        ST_BAD_ID    = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SLOT_SCAN,
        S_DECIDE,
        S_MAP_SCAN,
        S_FREE_WR,
        S_RESP
    } state_t;

    typedef struct packed {
        status_t              status;
        logic [SLOT_W-1:0]    slot;
        logic [BLOCK_W-1:0]   block;
    } res_t;

    // Bit index of a one-hot word.
    function automatic logic [WORD_LOG-1:0] enc_onehot(input logic [WORD_W-1:0] oh);
        logic [WORD_LOG-1:0] idx;
        idx = '0;
        for (int i = 0; i < WORD_W; i++) begin
            idx = idx | (WORD_LOG'(i) & {WORD_LOG{oh[i]}});
        end
        return idx;
    endfunction

endpackage

@@ rtl/core/ftba_slot_mem.sv @@
// Slot table memory: file id and block per slot, with per-slot valid flags.
module ftba_slot_mem import ftba_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int BW    = 9,
    parameter int AW    = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic          rd_valid,
    output logic [ID_W-1:0] rd_id,
    output logic [BW-1:0] rd_block,
    input  logic          wr_en,
    input  logic          clr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [ID_W-1:0] wr_id,
    input  logic [BW-1:0] wr_block
);

    logic [ID_W-1:0] id_ram    [DEPTH];
    logic [BW-1:0]   block_ram [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic             rd_valid_reg;
    logic [ID_W-1:0]  rd_id_reg;
    logic [BW-1:0]    rd_block_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            id_ram[wr_addr]    <= wr_id;
            block_ram[wr_addr] <= wr_block;
        end
        if (rd_en) begin
            rd_id_reg    <= id_ram[rd_addr];
            rd_block_reg <= block_ram[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end else if (clr_en) begin
                valid_reg[wr_addr] <= 1'b0;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_valid = rd_valid_reg;
    assign rd_id    = rd_id_reg;
    assign rd_block = rd_block_reg;

endmodule

@@ rtl/core/ftba_map_mem.sv @@
// Free-block bitmap memory, 32 blocks a word; unwritten words read as reset value.
module ftba_map_mem import ftba_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [WORD_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [WORD_W-1:0] wr_data
);

    logic [WORD_W-1:0] map_ram [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [WORD_W-1:0] ram_q_reg;
    logic              hit_reg;
    logic              word0_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            map_ram[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            ram_q_reg <= map_ram[rd_addr];
            word0_reg <= (rd_addr == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_comb begin
        if (hit_reg) begin
            rd_data = ram_q_reg;
        end else if (word0_reg) begin
            rd_data = RESET_WORD0;
        end else begin
            rd_data = '0;
        end
    end

endmodule

@@ rtl/core/ftba_ctrl.sv @@
// Command sequencer: slot scan, free-map scan, read-modify-write and result register.
module ftba_ctrl import ftba_pkg::*; #(
    parameter int SLOTS  = 16,
    parameter int BLOCKS = 512,
    parameter int SAW    = 4,
    parameter int BW     = 9,
    parameter int NW     = 16,
    parameter int WIW    = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [CMD_W-1:0]   s_cmd,
    input  logic [ID_W-1:0]    s_file_id,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic [SLOT_W-1:0]  m_slot,
    output logic [BLOCK_W-1:0] m_block,
    output logic               slot_rd_en,
    output logic [SAW-1:0]     slot_rd_addr,
    input  logic               slot_rd_valid,
    input  logic [ID_W-1:0]    slot_rd_id,
    input  logic [BW-1:0]      slot_rd_block,
    output logic               slot_wr_en,
    output logic               slot_clr_en,
    output logic [SAW-1:0]     slot_wr_addr,
    output logic [ID_W-1:0]    slot_wr_id,
    output logic [BW-1:0]      slot_wr_block,
    output logic               map_rd_en,
    output logic [WIW-1:0]     map_rd_addr,
    input  logic [WORD_W-1:0]  map_rd_data,
    output logic               map_wr_en,
    output logic [WIW-1:0]     map_wr_addr,
    output logic [WORD_W-1:0]  map_wr_data
);

    localparam int LAST_BITS = BLOCKS - (NW - 1) * WORD_W;
    localparam logic [WORD_W-1:0] PAD_MASK =
        (LAST_BITS == WORD_W) ? '0 : ~((32'd1 << LAST_BITS) - 32'd1);

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [SAW-1:0]    cnt_reg, cnt_next;
    logic [WIW-1:0]    wcnt_reg, wcnt_next;
    logic              found_reg, found_next;
    logic [SAW-1:0]    mslot_reg, mslot_next;
    logic [BW-1:0]     mblock_reg, mblock_next;
    logic              efound_reg, efound_next;
    logic [SAW-1:0]    eslot_reg, eslot_next;
    res_t              res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    res_t              m_res_reg, m_res_next;

    logic              slot_last;
    logic              word_last;
    logic              slot_hit;
    logic [WORD_W-1:0] map_word;
    logic [WORD_W-1:0] zero_bits;
    logic [WORD_W-1:0] zero_oh;
    logic              have_free;
    logic [WORD_LOG-1:0] free_bit;
    logic [BW-1:0]     free_block;
    logic [WIW-1:0]    own_word;
    logic              out_free;

    assign slot_last  = (cnt_reg == SAW'(SLOTS - 1));
    assign word_last  = (wcnt_reg == WIW'(NW - 1));
    assign slot_hit   = slot_rd_valid && (slot_rd_id == id_reg);
    assign map_word   = map_rd_data | (word_last ? PAD_MASK : '0);
    assign zero_bits  = ~map_word;
    assign zero_oh    = zero_bits & (~zero_bits + 32'd1);
    assign have_free  = |zero_bits;
    assign free_bit   = enc_onehot(zero_oh);
    assign free_block = BW'({wcnt_reg, free_bit});
    assign own_word   = WIW'(mblock_reg >> WORD_LOG);
    assign out_free   = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        id_reg     <= id_next;
        cnt_reg    <= cnt_next;
        wcnt_reg   <= wcnt_next;
        found_reg  <= found_next;
        mslot_reg  <= mslot_next;
        mblock_reg <= mblock_next;
        efound_reg <= efound_next;
        eslot_reg  <= eslot_next;
        res_reg    <= res_next;
        m_res_reg  <= m_res_next;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = (s_file_id == '0) ? S_RESP : S_SLOT_SCAN;
                end
            end
            S_SLOT_SCAN: begin
                if (slot_last) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                state_next = S_RESP;
                if (cmd_reg == CMD_CREATE && !found_reg && efound_reg) begin
                    state_next = S_MAP_SCAN;
                end else if (cmd_reg == CMD_DELETE && found_reg) begin
                    state_next = S_FREE_WR;
                end
            end
            S_MAP_SCAN: begin
                if (have_free || word_last) begin
                    state_next = S_RESP;
                end
            end
            S_FREE_WR: state_next = S_RESP;
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd_next      = cmd_reg;
        id_next       = id_reg;
        cnt_next      = cnt_reg;
        wcnt_next     = wcnt_reg;
        found_next    = found_reg;
        mslot_next    = mslot_reg;
        mblock_next   = mblock_reg;
        efound_next   = efound_reg;
        eslot_next    = eslot_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_res_next    = m_res_reg;
        s_ready       = 1'b0;
        slot_rd_en    = 1'b0;
        slot_rd_addr  = '0;
        slot_wr_en    = 1'b0;
        slot_clr_en   = 1'b0;
        slot_wr_addr  = eslot_reg;
        slot_wr_id    = id_reg;
        slot_wr_block = free_block;
        map_rd_en     = 1'b0;
        map_rd_addr   = '0;
        map_wr_en     = 1'b0;
        map_wr_addr   = wcnt_reg;
        map_wr_data   = map_rd_data | zero_oh;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next    = cmd_t'(s_cmd);
                    id_next     = s_file_id;
                    cnt_next    = '0;
                    wcnt_next   = '0;
                    found_next  = 1'b0;
                    efound_next = 1'b0;
                    if (s_file_id == '0) begin
                        res_next = '{status: ST_BAD_ID, slot: '0, block: '0};
                    end else begin
                        slot_rd_en = 1'b1;
                    end
                end
            end
            S_SLOT_SCAN: begin
                if (slot_hit && !found_reg) begin
                    found_next  = 1'b1;
                    mslot_next  = cnt_reg;
                    mblock_next = slot_rd_block;
                end
                if (!slot_rd_valid && !efound_reg) begin
                    efound_next = 1'b1;
                    eslot_next  = cnt_reg;
                end
                if (!slot_last) begin
                    cnt_next     = cnt_reg + 1'b1;
                    slot_rd_en   = 1'b1;
                    slot_rd_addr = cnt_reg + 1'b1;
                end
            end
            S_DECIDE: begin
                unique case (cmd_reg)
                    CMD_CREATE: begin
                        if (found_reg) begin
                            res_next = '{status: ST_EXISTS, slot: '0, block: '0};
                        end else if (!efound_reg) begin
                            res_next = '{status: ST_NO_SLOT, slot: '0, block: '0};
                        end else begin
                            map_rd_en = 1'b1;
                        end
                    end
                    CMD_DELETE: begin
                        if (!found_reg) begin
                            res_next = '{status: ST_NOT_FOUND, slot: '0, block: '0};
                        end else begin
                            res_next = '{status: ST_OK, slot: SLOT_W'(mslot_reg),
                                         block: BLOCK_W'(mblock_reg)};
                            slot_clr_en  = 1'b1;
                            slot_wr_addr = mslot_reg;
                            map_rd_en    = 1'b1;
                            map_rd_addr  = own_word;
                        end
                    end
                    default: begin
                        if (found_reg) begin
                            res_next = '{status: ST_OK, slot: SLOT_W'(mslot_reg),
                                         block: BLOCK_W'(mblock_reg)};
                        end else begin
                            res_next = '{status: ST_NOT_FOUND, slot: '0, block: '0};
                        end
                    end
                endcase
            end
            S_MAP_SCAN: begin
                if (have_free) begin
                    map_wr_en  = 1'b1;
                    slot_wr_en = 1'b1;
                    res_next   = '{status: ST_OK, slot: SLOT_W'(eslot_reg),
                                   block: BLOCK_W'(free_block)};
                end else if (word_last) begin
                    res_next = '{status: ST_NO_BLOCK, slot: '0, block: '0};
                end else begin
                    wcnt_next   = wcnt_reg + 1'b1;
                    map_rd_en   = 1'b1;
                    map_rd_addr = wcnt_reg + 1'b1;
                end
            end
            S_FREE_WR: begin
                map_wr_en   = 1'b1;
                map_wr_addr = own_word;
                map_wr_data = map_rd_data & ~(32'd1 << WORD_LOG'(mblock_reg));
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_res_next   = res_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_res_reg.status;
    assign m_slot   = m_res_reg.slot;
    assign m_block  = m_res_reg.block;

endmodule

@@ rtl/core/file_table_block_allocator.sv @@
// Top level of the file table with bitmap block allocator.
//
// Usage: one command word (s_cmd, s_file_id) on the s_ channel gives exactly one
// result word (m_status, m_slot, m_block) on the m_ channel, both valid/ready.
// Commands run one at a time; s_ready is high only while the sequencer idles.
// From accept, a zero id goes straight to the result register; every other command
// first scans all slots, one slot read per cycle, then decides. A successful delete
// adds a free-map read-modify-write. A create that reaches the map then scans
// free-map words, one word per cycle, until a free bit turns up or the last word is
// read (1 .. ceil(BLOCKS/32) words). The sequencer is back in idle before the next
// word is taken. The slot scan and the 32-bit free-map word port set the command
// duration.
// A result waits in the output register while m_ready is low; the next command
// is still accepted and holds in its final state until that word is taken.
// Reset (aresetn low, synchronous) empties the table and frees all blocks but
// 0 and 1 at once through per-entry valid flags; no clearing pass is needed.
module file_table_block_allocator import ftba_pkg::*; #(
    parameter int SLOTS  = 16,
    parameter int BLOCKS = 512
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [CMD_W-1:0]   s_cmd,
    input  logic [ID_W-1:0]    s_file_id,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic [SLOT_W-1:0]  m_slot,
    output logic [BLOCK_W-1:0] m_block
);

    // Slot address, block number width, free-map depth and address.
    localparam int SAW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int BW  = $clog2(BLOCKS);
    localparam int NW  = (BLOCKS + WORD_W - 1) / WORD_W;
    localparam int WIW = (NW > 1) ? $clog2(NW) : 1;

    logic              slot_rd_en;
    logic [SAW-1:0]    slot_rd_addr;
    logic              slot_rd_valid;
    logic [ID_W-1:0]   slot_rd_id;
    logic [BW-1:0]     slot_rd_block;
    logic              slot_wr_en;
    logic              slot_clr_en;
    logic [SAW-1:0]    slot_wr_addr;
    logic [ID_W-1:0]   slot_wr_id;
    logic [BW-1:0]     slot_wr_block;
    logic              map_rd_en;
    logic [WIW-1:0]    map_rd_addr;
    logic [WORD_W-1:0] map_rd_data;
    logic              map_wr_en;
    logic [WIW-1:0]    map_wr_addr;
    logic [WORD_W-1:0] map_wr_data;

    // Sequencer: owns the handshakes and the result register.
    ftba_ctrl #(
        .SLOTS  (SLOTS),
        .BLOCKS (BLOCKS),
        .SAW    (SAW),
        .BW     (BW),
        .NW     (NW),
        .WIW    (WIW)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_file_id     (s_file_id),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_slot        (m_slot),
        .m_block       (m_block),
        .slot_rd_en    (slot_rd_en),
        .slot_rd_addr  (slot_rd_addr),
        .slot_rd_valid (slot_rd_valid),
        .slot_rd_id    (slot_rd_id),
        .slot_rd_block (slot_rd_block),
        .slot_wr_en    (slot_wr_en),
        .slot_clr_en   (slot_clr_en),
        .slot_wr_addr  (slot_wr_addr),
        .slot_wr_id    (slot_wr_id),
        .slot_wr_block (slot_wr_block),
        .map_rd_en     (map_rd_en),
        .map_rd_addr   (map_rd_addr),
        .map_rd_data   (map_rd_data),
        .map_wr_en     (map_wr_en),
        .map_wr_addr   (map_wr_addr),
        .map_wr_data   (map_wr_data)
    );

    // Slot table: id and owned block per slot.
    ftba_slot_mem #(
        .DEPTH (SLOTS),
        .BW    (BW),
        .AW    (SAW)
    ) u_slot_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (slot_rd_en),
        .rd_addr  (slot_rd_addr),
        .rd_valid (slot_rd_valid),
        .rd_id    (slot_rd_id),
        .rd_block (slot_rd_block),
        .wr_en    (slot_wr_en),
        .clr_en   (slot_clr_en),
        .wr_addr  (slot_wr_addr),
        .wr_id    (slot_wr_id),
        .wr_block (slot_wr_block)
    );

    // Free map, one bit per block.
    ftba_map_mem #(
        .DEPTH (NW),
        .AW    (WIW)
    ) u_map_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (map_rd_en),
        .rd_addr (map_rd_addr),
        .rd_data (map_rd_data),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (map_wr_data)
    );

endmodule

@@ rtl/core/ftba_checker.sv @@
// Port-level checks of the allocator, bound to the top level.
module ftba_assert import ftba_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [CMD_W-1:0]   s_cmd,
    input logic [ID_W-1:0]    s_file_id,
    input logic               m_valid,
    input logic               m_ready,
    input logic [2:0]         m_status,
    input logic [SLOT_W-1:0]  m_slot,
    input logic [BLOCK_W-1:0] m_block
);

    // Stalled result word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_slot)
                                && $stable(m_block))
        else $error("result word changed while stalled");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= ST_BAD_ID)
        else $error("undefined status code");

    // A failed command reports neither slot nor block.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_slot == '0 && m_block == '0)
        else $error("failed command carries slot or block");

    // One command at a time: nothing is taken in the cycle after an accept.
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second command taken back to back");

endmodule

bind file_table_block_allocator ftba_assert u_ftba_checker (.*);

@@ tb/ftba_checker.sv @@
// Checker for the file table block allocator: predicts each command word and compares results.
module ftba_checker import ftba_pkg::*; #(
    parameter int SLOTS  = 16,
    parameter int BLOCKS = 512
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [CMD_W-1:0]   s_cmd,
    input  logic [ID_W-1:0]    s_file_id,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [2:0]         m_status,
    input  logic [SLOT_W-1:0]  m_slot,
    input  logic [BLOCK_W-1:0] m_block,
    output int                 fail_cnt,
    output int                 pending,
    output int                 n_results,
    output int                 n_ok,
    output int                 n_not_found,
    output int                 n_exists,
    output int                 n_no_slot,
    output int                 n_bad_id
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [ID_W-1:0]    file_at [SLOTS];
    logic [BLOCK_W-1:0] blk_of  [SLOTS];
    bit                 in_use  [BLOCKS];
    res_t               expected_q [$];

    initial begin
        fail_cnt    = 0;
        pending     = 0;
        n_results   = 0;
        n_ok        = 0;
        n_not_found = 0;
        n_exists    = 0;
        n_no_slot   = 0;
        n_bad_id    = 0;
    end

    // First slot holding id, SLOTS if none.
    function automatic int find_file(logic [ID_W-1:0] id);
        for (int i = 0; i < SLOTS; i++) begin
            if (file_at[i] == id) return i;
        end
        return SLOTS;
    endfunction

    // Applies one command word to the table and free map, returns the expected result.
    function automatic res_t apply_cmd(cmd_t op, logic [ID_W-1:0] id);
        res_t r;
        int   s;
        int   f;
        int   b;
        r.status = ST_OK;
        r.slot   = '0;
        r.block  = '0;
        if (id == '0) begin
            r.status = ST_BAD_ID;
            return r;
        end
        s = find_file(id);
        if (op == CMD_CREATE) begin
            if (s < SLOTS) begin
                r.status = ST_EXISTS;
            end else begin
                f = find_file('0);
                b = BLOCKS;
                for (int i = BLOCKS - 1; i >= 0; i--) begin
                    if (!in_use[i]) b = i;
                end
                if (f >= SLOTS) begin
                    r.status = ST_NO_SLOT;
                end else if (b >= BLOCKS) begin
                    r.status = ST_NO_BLOCK;
                end else begin
                    in_use[b]  = 1'b1;
                    file_at[f] = id;
                    blk_of[f]  = BLOCK_W'(b);
                    r.slot     = SLOT_W'(f);
                    r.block    = BLOCK_W'(b);
                end
            end
        end else if (s >= SLOTS) begin
            r.status = ST_NOT_FOUND;
        end else begin
            // lookup, delete and the spare code all report the file's slot and block
            r.slot  = SLOT_W'(s);
            r.block = blk_of[s];
            if (op == CMD_DELETE) begin
                in_use[blk_of[s]] = 1'b0;
                file_at[s]        = '0;
                blk_of[s]         = '0;
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        res_t want;
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                file_at[i] = '0;
                blk_of[i]  = '0;
            end
            for (int i = 0; i < BLOCKS; i++) in_use[i] = (i < 2);
            expected_q.delete();
        end else begin
            if (s_valid && s_ready) expected_q.push_back(apply_cmd(cmd_t'(s_cmd), s_file_id));
            if (m_valid && m_ready) begin
                n_results++;
                case (status_t'(m_status))
                    ST_OK:        n_ok++;
                    ST_NOT_FOUND: n_not_found++;
                    ST_EXISTS:    n_exists++;
                    ST_NO_SLOT:   n_no_slot++;
                    ST_BAD_ID:    n_bad_id++;
                    default:      ;
                endcase
                if (expected_q.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: unexpected result word status %0d slot %0d block %0d",
                             $realtime, m_status, m_slot, m_block);
                end else begin
                    want = expected_q.pop_front();
                    if (m_status != want.status) begin
                        fail_cnt++;
                        $display("%0t: status expected %0d got %0d",
                                 $realtime, want.status, m_status);
                    end
                    if (m_slot != want.slot) begin
                        fail_cnt++;
                        $display("%0t: slot expected %0d got %0d",
                                 $realtime, want.slot, m_slot);
                    end
                    if (m_block != want.block) begin
                        fail_cnt++;
                        $display("%0t: block expected %0d got %0d",
                                 $realtime, want.block, m_block);
                    end
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

@@ tb/tb_file_table_block_allocator.sv @@
// Testbench top: drives command words into the allocator and gives the verdict.
module tb_file_table_block_allocator import ftba_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1920;
    localparam int QUIET_TAIL   = 200;   // final words: idling stays off in every phase that starts within them
    localparam int STALL_LIMIT  = 2000;  // cycles with no handshake before giving up
    localparam int POOL_N       = 20;    // more ids than slots, so the table can fill

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic [CMD_W-1:0]   s_cmd     = CMD_LOOKUP;
    logic [ID_W-1:0]    s_file_id = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic [2:0]         m_status;
    logic [SLOT_W-1:0]  m_slot;
    logic [BLOCK_W-1:0] m_block;

    int fail_cnt, pending, n_results, n_ok, n_not_found, n_exists, n_no_slot, n_bad_id;

    bit             pace_on = 1'b0;   // random idling on both channels
    int             stall_left = 0;
    int             quiet_cycles = 0;
    int             n_sent = 0;
    logic [ID_W-1:0] id_pool [POOL_N];

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    file_table_block_allocator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_cmd     (s_cmd),
        .s_file_id (s_file_id),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_status  (m_status),
        .m_slot    (m_slot),
        .m_block   (m_block)
    );

    ftba_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_file_id   (s_file_id),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_slot      (m_slot),
        .m_block     (m_block),
        .fail_cnt    (fail_cnt),
        .pending     (pending),
        .n_results   (n_results),
        .n_ok        (n_ok),
        .n_not_found (n_not_found),
        .n_exists    (n_exists),
        .n_no_slot   (n_no_slot),
        .n_bad_id    (n_bad_id)
    );

    // Result side back-pressure: random bursts with m_ready low.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (pace_on && aresetn && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 6);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: counts cycles in which neither channel moves a word.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $realtime, STALL_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Presents one command word; called and returns at a falling edge.
    // Valid stays high into the next word unless a gap is drawn.
    task automatic send_word(input cmd_t op, input logic [ID_W-1:0] id);
        int gap;
        if (pace_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_cmd     <= op;
        s_file_id <= id;
        do @(posedge aclk); while (!s_ready);
        n_sent++;
        @(negedge aclk);
    endtask

    // Command mix per phase: 0 mixed, 1 filling (create heavy), 2 draining (delete heavy).
    function automatic cmd_t pick_cmd(int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            1:       return (r < 65) ? CMD_CREATE : (r < 80) ? CMD_LOOKUP :
                            (r < 95) ? CMD_DELETE : CMD_RSVD;
            2:       return (r < 60) ? CMD_DELETE : (r < 80) ? CMD_LOOKUP :
                            (r < 95) ? CMD_CREATE : CMD_RSVD;
            default: return (r < 35) ? CMD_CREATE : (r < 65) ? CMD_DELETE :
                            (r < 93) ? CMD_LOOKUP : CMD_RSVD;
        endcase
    endfunction

    // Mostly ids from a small pool so that hits and duplicates are common.
    function automatic logic [ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return '0;
        if (r < 15) return ID_W'($urandom_range(1, 65535));
        return id_pool[$urandom_range(0, POOL_N - 1)];
    endfunction

    initial begin
        int mode;
        for (int i = 0; i < POOL_N; i++) id_pool[i] = ID_W'($urandom_range(1, 65535));

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: zero id on every command, including the spare code
        send_word(CMD_LOOKUP, '0);
        send_word(CMD_CREATE, '0);
        send_word(CMD_DELETE, '0);
        send_word(CMD_RSVD,   '0);
        // missing file on lookup and delete
        send_word(CMD_LOOKUP, 16'hFFFF);
        send_word(CMD_DELETE, 16'hFFFF);
        // create, duplicate create, spare code acting as lookup
        send_word(CMD_CREATE, 16'hFFFF);
        send_word(CMD_CREATE, 16'hFFFF);
        send_word(CMD_RSVD,   16'hFFFF);
        // fill the remaining slots with walking-one ids
        for (int i = 0; i < 15; i++) send_word(CMD_CREATE, ID_W'(1) << i);
        // table full: new id has no slot, known id still reports a duplicate first
        send_word(CMD_CREATE, 16'h8000);
        send_word(CMD_CREATE, 16'hFFFF);
        // delete frees slot 0 and its block, second delete misses, slot is reused
        send_word(CMD_DELETE, 16'hFFFF);
        send_word(CMD_DELETE, 16'hFFFF);
        send_word(CMD_CREATE, 16'h8000);

        // random phases of 60 words; idling switched per phase, none in the tail
        mode = 2;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 60 == 0) begin
                if (n > 0) mode = $urandom_range(0, 2);
                pace_on = (n < RANDOM_WORDS - QUIET_TAIL) && ($urandom_range(0, 9) < 7);
            end
            send_word(pick_cmd(mode), pick_id());
        end
        s_valid <= 1'b0;
        pace_on = 1'b0;

        // drain, then let the sequencer settle back to idle
        wait (pending == 0);
        repeat (64) @(posedge aclk);

        $display("%0d command words sent, %0d results checked", n_sent, n_results);
        $display("ok %0d, not found %0d, exists %0d, table full %0d, zero id %0d",
                 n_ok, n_not_found, n_exists, n_no_slot, n_bad_id);
        if (fail_cnt == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
